// ----- rtl/loop_wrapping_sample_position_counter_defines.svh -----
// ----------------------------------------------------------------------------
// loop_wrapping_sample_position_counter_defines.svh
// assertion macros shared by the position counter rtl
// ----------------------------------------------------------------------------
`ifndef LOOP_WRAPPING_SAMPLE_POSITION_COUNTER_DEFINES_SVH
`define LOOP_WRAPPING_SAMPLE_POSITION_COUNTER_DEFINES_SVH

`ifndef SYNTH

// check outside of reset
`define LWSPC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check at every edge, reset included
`define LWSPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define LWSPC_ASSERT(lbl, clk, rst_n, prop, msg)

`define LWSPC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- rtl/lwspc_pkg.sv -----
// ----------------------------------------------------------------------------
// lwspc_pkg
// types and constants of the loop wrapping sample position counter
// ----------------------------------------------------------------------------
package lwspc_pkg;

  localparam int unsigned REQ_W      = 2;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned BEAT_W     = 32;
  localparam int unsigned POS_W      = 63;
  localparam int unsigned TEMPO_W    = 19;
  localparam int unsigned RATE_W     = 19;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // rate * 60000 fits in 35 bits for any 19 bit rate
  localparam int unsigned MULT_W     = 35;
  localparam int unsigned PROD_W     = BEAT_W + MULT_W;
  localparam int unsigned DIVISOR_W  = POS_W;
  localparam int unsigned DIVIDEND_W = PROD_W;
  localparam int unsigned MUL_CNT_W  = $clog2(BEAT_W + 1);
  localparam int unsigned DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

  localparam logic [TEMPO_W-1:0] TEMPO_MIN    = TEMPO_W'(20000);
  localparam logic [TEMPO_W-1:0] TEMPO_MAX    = TEMPO_W'(300000);
  localparam logic [RATE_W-1:0]  RATE_DEFAULT = RATE_W'(44100);
  localparam logic [15:0]        MS_PER_MIN   = 16'd60000;
  localparam logic [POS_W-1:0]   POS_MAX      = {POS_W{1'b1}};

  localparam logic [TEMPO_W-1:0] TEMPO_RESET = TEMPO_W'(120000);
  localparam logic [RATE_W-1:0]  RATE_RESET  = RATE_W'(44100);

  typedef enum logic [REQ_W-1:0] {
    REQ_ADVANCE = 2'd0,
    REQ_PLAY    = 2'd1,
    REQ_STOP    = 2'd2,
    REQ_LOCATE  = 2'd3
  } req_type_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMPO      = 3'd0,
    CFG_RATE       = 3'd1,
    CFG_LOOP_START = 3'd2,
    CFG_LOOP_END   = 3'd3,
    CFG_LOOP_EN    = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_WRAP,
    ST_MOD,
    ST_DONE
  } fsm_state_e;

  typedef enum logic [1:0] {
    PH_LOCATE,
    PH_LOOP_START,
    PH_LOOP_END
  } conv_phase_e;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [COUNT_W-1:0] sample_count;
    logic [BEAT_W-1:0]  locate_beat;
  } in_req_t;

  typedef struct packed {
    logic [POS_W-1:0] position_samples;
    logic             is_running;
  } out_rsp_t;

  typedef struct packed {
    logic              start;
    logic [BEAT_W-1:0] beat;
    logic [MULT_W-1:0] mult;
  } mul_req_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

endpackage

// ----- rtl/lwspc_mul.sv -----
// ----------------------------------------------------------------------------
// lwspc_mul
// bit serial shift and add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module lwspc_mul (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lwspc_pkg::mul_req_t               req_i,
  output logic                              done_o,
  output logic [lwspc_pkg::PROD_W-1:0]      prod_o
);

  logic                              busy_q, busy_d;
  logic [lwspc_pkg::MUL_CNT_W-1:0]   cnt_q, cnt_d;
  logic [lwspc_pkg::MULT_W-1:0]      mult_q;
  logic [lwspc_pkg::MULT_W-1:0]      hi_q;
  logic [lwspc_pkg::BEAT_W-1:0]      lo_q;
  logic [lwspc_pkg::MULT_W:0]        sum;

  // partial sum of the upper half plus the multiplicand when the low bit is set
  assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mult_q} : '0);

  assign done_o = busy_q && (cnt_q == '0);
  assign prod_o = {hi_q, lo_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = lwspc_pkg::MUL_CNT_W'(lwspc_pkg::BEAT_W);
    end else if (done_o) begin
      busy_d = 1'b0;
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mult_q <= req_i.mult;
      hi_q   <= '0;
      lo_q   <= req_i.beat;
    end else if (busy_q && (cnt_q != '0)) begin
      hi_q <= sum[lwspc_pkg::MULT_W:1];
      lo_q <= {sum[0], lo_q[lwspc_pkg::BEAT_W-1:1]};
    end
  end

endmodule

// ----- rtl/lwspc_div.sv -----
// ----------------------------------------------------------------------------
// lwspc_div
// bit serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module lwspc_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  lwspc_pkg::div_req_t                req_i,
  output logic                               done_o,
  output logic [lwspc_pkg::DIVIDEND_W-1:0]   quot_o,
  output logic [lwspc_pkg::DIVISOR_W-1:0]    rem_o
);

  logic                               busy_q, busy_d;
  logic [lwspc_pkg::DIV_CNT_W-1:0]    cnt_q, cnt_d;
  logic [lwspc_pkg::DIVISOR_W-1:0]    dvs_q;
  logic [lwspc_pkg::DIVISOR_W-1:0]    rem_q;
  logic [lwspc_pkg::DIVIDEND_W-1:0]   dq_q;
  logic [lwspc_pkg::DIVISOR_W:0]      trial;
  logic [lwspc_pkg::DIVISOR_W:0]      diff;
  logic                               fits;

  // shift the next dividend bit into the partial remainder
  assign trial = {rem_q, dq_q[lwspc_pkg::DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  assign done_o = busy_q && (cnt_q == '0);
  assign quot_o = dq_q;
  assign rem_o  = rem_q;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = lwspc_pkg::DIV_CNT_W'(lwspc_pkg::DIVIDEND_W);
    end else if (done_o) begin
      busy_d = 1'b0;
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // dividend shifts out at the top while quotient bits enter at the bottom
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvs_q <= req_i.divisor;
      rem_q <= '0;
      dq_q  <= req_i.dividend;
    end else if (busy_q && (cnt_q != '0)) begin
      rem_q <= fits ? diff[lwspc_pkg::DIVISOR_W-1:0] : trial[lwspc_pkg::DIVISOR_W-1:0];
      dq_q  <= {dq_q[lwspc_pkg::DIVIDEND_W-2:0], fits};
    end
  end

endmodule

// ----- rtl/loop_wrapping_sample_position_counter.sv -----
// ----------------------------------------------------------------------------
// loop_wrapping_sample_position_counter
// transport position counter in samples with play, stop, locate and loop wrap
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+--------------------------
//  in      | into      | in_valid_i / in_stall_o    | in_req_i  (in_req_t)
//  out     | out of    | out_valid_o / out_stall_i  | out_rsp_o (out_rsp_t)
//  cfg     | into      | cfg_we_i, no wait          | cfg_idx_i, cfg_wdata_i
//
//  play, stop, advance while stopped or without loop: no conversion, straight to the result
//  locate: one beat conversion (32 multiply + 67 divide steps)
//  looped advance: two conversions, plus a 67 step modulo when it wraps
//  the serial multiplier and the serial divider carry out the conversions
//  reset: asynchronous, clears position and flag, loads register defaults
//  a stalled result waits in the output register; the next request is taken
//  as soon as the sequencer is back in idle
// ----------------------------------------------------------------------------
`include "loop_wrapping_sample_position_counter_defines.svh"

module loop_wrapping_sample_position_counter #(
  parameter int unsigned BEAT_FRACTION_BITS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  lwspc_pkg::in_req_t                  in_req_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output lwspc_pkg::out_rsp_t                 out_rsp_o,
  // configuration writes
  input  logic                                cfg_we_i,
  input  logic [lwspc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [lwspc_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  // configuration registers
  logic [lwspc_pkg::TEMPO_W-1:0] tempo_q;
  logic [lwspc_pkg::RATE_W-1:0]  rate_q;
  logic [lwspc_pkg::BEAT_W-1:0]  loop_start_q;
  logic [lwspc_pkg::BEAT_W-1:0]  loop_end_q;
  logic                          loop_en_q;

  // transport state
  logic [lwspc_pkg::POS_W-1:0]   position_q;
  logic                          running_q;

  // sequencer
  lwspc_pkg::fsm_state_e         state_q, state_d;
  lwspc_pkg::conv_phase_e        phase_q, phase_d;
  logic [lwspc_pkg::POS_W-1:0]   pos_new_q, pos_new_d;
  logic                          run_new_q, run_new_d;
  logic [lwspc_pkg::POS_W-1:0]   s_q, s_d;
  logic [lwspc_pkg::POS_W-1:0]   e_q, e_d;

  // result register
  logic                          out_valid_q, out_valid_d;
  lwspc_pkg::out_rsp_t           out_rsp_q;
  logic                          out_load;

  // arithmetic units
  lwspc_pkg::mul_req_t                  mul_req;
  logic                                 mul_done;
  logic [lwspc_pkg::PROD_W-1:0]         mul_prod;
  lwspc_pkg::div_req_t                  div_req;
  logic                                 div_done;
  logic [lwspc_pkg::DIVIDEND_W-1:0]     div_quot;
  logic [lwspc_pkg::DIVISOR_W-1:0]      div_rem;

  // derived operands
  logic [lwspc_pkg::TEMPO_W-1:0]        tempo_eff;
  logic [lwspc_pkg::RATE_W-1:0]         rate_eff;
  logic [lwspc_pkg::MULT_W-1:0]         mult_val;
  logic [lwspc_pkg::DIVISOR_W-1:0]      den;
  logic [lwspc_pkg::POS_W:0]            adv_sum;
  logic [lwspc_pkg::POS_W-1:0]          adv_pos;
  logic [lwspc_pkg::POS_W-1:0]          conv_sat;
  logic [lwspc_pkg::POS_W-1:0]          pos_wrap;
  logic                                 wrap_ok;
  logic                                 in_accept;
  lwspc_pkg::req_type_e                 req_type;

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tempo_q      <= lwspc_pkg::TEMPO_RESET;
      rate_q       <= lwspc_pkg::RATE_RESET;
      loop_start_q <= '0;
      loop_end_q   <= '0;
      loop_en_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lwspc_pkg::CFG_TEMPO:      tempo_q      <= cfg_wdata_i[lwspc_pkg::TEMPO_W-1:0];
        lwspc_pkg::CFG_RATE:       rate_q       <= cfg_wdata_i[lwspc_pkg::RATE_W-1:0];
        lwspc_pkg::CFG_LOOP_START: loop_start_q <= cfg_wdata_i[lwspc_pkg::BEAT_W-1:0];
        lwspc_pkg::CFG_LOOP_END:   loop_end_q   <= cfg_wdata_i[lwspc_pkg::BEAT_W-1:0];
        lwspc_pkg::CFG_LOOP_EN:    loop_en_q    <= cfg_wdata_i[0];
        default: ;  // unused register index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // beat to sample conversion operands
  // samples = beat * 60000 * rate / (tempo << BEAT_FRACTION_BITS), truncated
  // ---------------------------------------------------------------------------
  // tempo clamped to the legal range so the divisor is never zero
  assign tempo_eff = (tempo_q < lwspc_pkg::TEMPO_MIN) ? lwspc_pkg::TEMPO_MIN :
                     (tempo_q > lwspc_pkg::TEMPO_MAX) ? lwspc_pkg::TEMPO_MAX : tempo_q;
  // zero rate falls back to the default
  assign rate_eff  = (rate_q == '0) ? lwspc_pkg::RATE_DEFAULT : rate_q;
  // constant multiply, latched by the multiplier at start
  assign mult_val  = lwspc_pkg::MULT_W'(rate_eff) * lwspc_pkg::MULT_W'(lwspc_pkg::MS_PER_MIN);
  assign den       = {{(lwspc_pkg::DIVISOR_W - lwspc_pkg::TEMPO_W){1'b0}}, tempo_eff}
                     << BEAT_FRACTION_BITS;

  // quotient saturates at the largest position
  assign conv_sat = (|div_quot[lwspc_pkg::DIVIDEND_W-1:lwspc_pkg::POS_W]) ?
                    lwspc_pkg::POS_MAX : div_quot[lwspc_pkg::POS_W-1:0];

  // advanced position, saturating before any wrap
  assign adv_sum = {1'b0, position_q} +
                   {{(lwspc_pkg::POS_W + 1 - lwspc_pkg::COUNT_W){1'b0}}, in_req_i.sample_count};
  assign adv_pos = adv_sum[lwspc_pkg::POS_W] ? lwspc_pkg::POS_MAX
                                             : adv_sum[lwspc_pkg::POS_W-1:0];

  // wrap only inside a non-empty loop and at or past its end
  assign wrap_ok  = (e_q > s_q) && (pos_new_q >= e_q);
  // remainder is below the loop length, so this stays below the loop end
  assign pos_wrap = s_q + div_rem;

  assign in_accept = in_valid_i && !in_stall_o;
  assign req_type  = lwspc_pkg::req_type_e'(in_req_i.req_type);

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lwspc_pkg::ST_IDLE;
      phase_q <= lwspc_pkg::PH_LOCATE;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_new_q <= pos_new_d;
    run_new_q <= run_new_d;
    s_q       <= s_d;
    e_q       <= e_d;
  end

  always_comb begin
    state_d          = state_q;
    phase_d          = phase_q;
    pos_new_d        = pos_new_q;
    run_new_d        = run_new_q;
    s_d              = s_q;
    e_d              = e_q;
    mul_req.start    = 1'b0;
    mul_req.beat     = loop_end_q;
    mul_req.mult     = mult_val;
    div_req.start    = 1'b0;
    div_req.dividend = mul_prod;
    div_req.divisor  = den;
    out_load         = 1'b0;

    unique case (state_q)
      lwspc_pkg::ST_IDLE: begin
        pos_new_d = position_q;
        run_new_d = running_q;
        if (in_accept) begin
          unique case (req_type)
            lwspc_pkg::REQ_PLAY: begin
              run_new_d = 1'b1;
              state_d   = lwspc_pkg::ST_DONE;
            end
            lwspc_pkg::REQ_STOP: begin
              run_new_d = 1'b0;
              state_d   = lwspc_pkg::ST_DONE;
            end
            lwspc_pkg::REQ_LOCATE: begin
              mul_req.start = 1'b1;
              mul_req.beat  = in_req_i.locate_beat;
              phase_d       = lwspc_pkg::PH_LOCATE;
              state_d       = lwspc_pkg::ST_MUL;
            end
            default: begin  // advance
              if (!running_q) begin
                state_d = lwspc_pkg::ST_DONE;
              end else if (!loop_en_q) begin
                pos_new_d = adv_pos;
                state_d   = lwspc_pkg::ST_DONE;
              end else begin
                // convert loop start first, then loop end
                pos_new_d     = adv_pos;
                mul_req.start = 1'b1;
                mul_req.beat  = loop_start_q;
                phase_d       = lwspc_pkg::PH_LOOP_START;
                state_d       = lwspc_pkg::ST_MUL;
              end
            end
          endcase
        end
      end

      lwspc_pkg::ST_MUL: begin
        if (mul_done) begin
          div_req.start = 1'b1;
          state_d       = lwspc_pkg::ST_DIV;
        end
      end

      lwspc_pkg::ST_DIV: begin
        if (div_done) begin
          unique case (phase_q)
            lwspc_pkg::PH_LOCATE: begin
              pos_new_d = conv_sat;
              state_d   = lwspc_pkg::ST_DONE;
            end
            lwspc_pkg::PH_LOOP_START: begin
              s_d           = conv_sat;
              mul_req.start = 1'b1;
              mul_req.beat  = loop_end_q;
              phase_d       = lwspc_pkg::PH_LOOP_END;
              state_d       = lwspc_pkg::ST_MUL;
            end
            default: begin  // loop end
              e_d     = conv_sat;
              state_d = lwspc_pkg::ST_WRAP;
            end
          endcase
        end
      end

      lwspc_pkg::ST_WRAP: begin
        // offset into the loop modulo the loop length
        div_req.dividend = {{(lwspc_pkg::DIVIDEND_W - lwspc_pkg::POS_W){1'b0}},
                            pos_new_q - s_q};
        div_req.divisor  = e_q - s_q;
        if (wrap_ok) begin
          div_req.start = 1'b1;
          state_d       = lwspc_pkg::ST_MOD;
        end else begin
          state_d = lwspc_pkg::ST_DONE;
        end
      end

      lwspc_pkg::ST_MOD: begin
        if (div_done) begin
          pos_new_d = pos_wrap;
          state_d   = lwspc_pkg::ST_DONE;
        end
      end

      lwspc_pkg::ST_DONE: begin
        // commit once the result register has room
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = lwspc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = lwspc_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != lwspc_pkg::ST_IDLE);

  // ---------------------------------------------------------------------------
  // transport state commits together with the result
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q <= '0;
      running_q  <= 1'b0;
    end else if (out_load) begin
      position_q <= pos_new_q;
      running_q  <= run_new_q;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_rsp_q.position_samples <= pos_new_q;
      out_rsp_q.is_running       <= run_new_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // ---------------------------------------------------------------------------
  // arithmetic units
  // ---------------------------------------------------------------------------
  lwspc_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  lwspc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot),
    .rem_o  (div_rem)
  );

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `LWSPC_ASSERT(a_state_holds, clk_i, rst_ni, !out_load |=> $stable(position_q) && $stable(running_q), "transport state changed without a result")
  `LWSPC_ASSERT(a_result_matches, clk_i, rst_ni, out_load |=> out_rsp_q.position_samples == position_q && out_rsp_q.is_running == running_q, "result differs from committed state")
  `LWSPC_ASSERT(a_accept_leaves_idle, clk_i, rst_ni, in_accept |=> state_q != lwspc_pkg::ST_IDLE, "accepted request left sequencer idle")
  `LWSPC_ASSERT(a_wrap_in_loop, clk_i, rst_ni, (state_q == lwspc_pkg::ST_MOD) && div_done |-> pos_wrap < e_q, "wrapped position not below loop end")
  `LWSPC_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !out_valid_o && !in_stall_o, "block not quiet in reset")

endmodule
